FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the Huffman tree decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HTD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/htd_pkg.sv
// Package with the types and constants of the Huffman tree decoder.
`default_nettype none

package htd_pkg;

  localparam int SYMBOL_COUNT    = 256;
  localparam int MAX_CODE_LENGTH = 31;
  localparam int NODE_CAPACITY   = 256;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [1:0] KIND_ABSENT = 2'd0;
  localparam logic [1:0] KIND_NODE   = 2'd1;
  localparam logic [1:0] KIND_LEAF   = 2'd2;

  // One child link: kind over a node index or a leaf symbol.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] val;
  } link_t;

  localparam link_t LINK_NONE = '{kind: KIND_ABSENT, val: 8'd0};

  // Write request into the node table.
  typedef struct packed {
    logic       we_left;
    logic       we_right;
    logic [7:0] addr;
    link_t      wdata;
  } mem_wr_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_NORM,
    ST_WALK_RD,
    ST_WALK,
    ST_ALLOC_CLR,
    ST_ALLOC_LINK,
    ST_LEAF,
    ST_DEC_RD,
    ST_DEC,
    ST_DEC_END
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/htd_node_mem.sv
// Node table memory: left and right child links, one write and one registered read port.
`default_nettype none

module htd_node_mem
  import htd_pkg::*;
(
  input  wire logic    clk,
  input  wire mem_wr_t wr,
  input  wire logic [7:0] raddr,
  output link_t        rd_left,
  output link_t        rd_right
);

  link_t mem_left  [NODE_CAPACITY];
  link_t mem_right [NODE_CAPACITY];

  // Writes to either half of an entry.
  always_ff @(posedge clk) begin
    if (wr.we_left) begin
      mem_left[wr.addr] <= wr.wdata;
    end
    if (wr.we_right) begin
      mem_right[wr.addr] <= wr.wdata;
    end
  end

  // Registered read of both links of one node.
  always_ff @(posedge clk) begin
    rd_left  <= mem_left[raddr];
    rd_right <= mem_right[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/huffman_tree_decoder_unit.sv
// Huffman tree decoder top level: code loading, tree walk and result output.
// Decode item: busy for a read, a step per valid bit and an end step; each result waits for
//   the next; the last leaves as busy falls; at most one result per cycle, never stalled.
// Load item: busy for normalize steps down to the marker bit, one read, one walk step
//   per existing node plus one, two per new node and a leaf write if any node was added.
// After reset busy stays high while the root entry is cleared.
`default_nettype none
`include "assert_macros.svh"

module huffman_tree_decoder_unit
  import htd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation,
  input  wire logic [7:0]  symbol,
  input  wire logic [31:0] code_word,
  input  wire logic [7:0]  data_byte,
  input  wire logic [3:0]  valid_bits,
  output logic             result_strobe,
  output logic [7:0]       decoded_symbol,
  output logic             bad_code,
  output logic             last
);

  state_t      state, state_next;
  logic [31:0] code_sr;
  logic [4:0]  bits_left;
  logic [7:0]  sym_reg;
  logic [7:0]  cur;
  logic [8:0]  nodes_used;
  logic [7:0]  current_node;
  logic [7:0]  data_sr;
  logic [3:0]  cnt;
  logic        pend_valid;
  logic [7:0]  pend_symbol;
  logic        pend_bad;

  mem_wr_t     mem_wr;
  logic [7:0]  raddr;
  link_t       rd_left, rd_right;

  logic        accept;
  logic        load_ok;
  logic [3:0]  cnt_start;
  logic        cur_dir;
  link_t       link_sel;
  logic        cap_over;
  logic [7:0]  dec_node_next;

  htd_node_mem u_mem (
    .clk      (clk),
    .wr       (mem_wr),
    .raddr    (raddr),
    .rd_left  (rd_left),
    .rd_right (rd_right)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Item checks and clamping at acceptance.
  assign load_ok   = (code_word[31:1] != 31'd0) && ({1'b0, symbol} < 9'(SYMBOL_COUNT));
  assign cnt_start = (valid_bits > 4'd8) ? 4'd8 : valid_bits;

  // Link selected by the current code or data bit.
  // The current bit needs no new node, so the path needs bits_left - 1 of them.
  assign cur_dir       = (state == ST_DEC) ? data_sr[7] : code_sr[31];
  assign link_sel      = cur_dir ? rd_right : rd_left;
  assign cap_over      = ({1'b0, nodes_used} + {5'd0, bits_left}) > 10'(NODE_CAPACITY + 1);
  assign dec_node_next = (link_sel.kind == KIND_NODE) ? link_sel.val : 8'd0;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_DECODE) begin
            state_next = (cnt_start == 4'd0) ? ST_IDLE : ST_DEC_RD;
          end else begin
            state_next = load_ok ? ST_NORM : ST_IDLE;
          end
        end
      end
      ST_NORM: begin
        if (code_sr[31]) begin
          state_next = (bits_left > 5'(MAX_CODE_LENGTH)) ? ST_IDLE : ST_WALK_RD;
        end
      end
      ST_WALK_RD: state_next = ST_WALK;
      ST_WALK: begin
        if (bits_left > 5'd1) begin
          if (link_sel.kind == KIND_LEAF) begin
            state_next = ST_IDLE;
          end else if (link_sel.kind == KIND_NODE) begin
            state_next = ST_WALK;
          end else begin
            state_next = cap_over ? ST_IDLE : ST_ALLOC_CLR;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ALLOC_CLR:  state_next = ST_ALLOC_LINK;
      ST_ALLOC_LINK: state_next = (bits_left > 5'd2) ? ST_ALLOC_CLR : ST_LEAF;
      ST_LEAF:       state_next = ST_IDLE;
      ST_DEC_RD:     state_next = ST_DEC;
      ST_DEC:        state_next = (cnt == 4'd1) ? ST_DEC_END : ST_DEC;
      ST_DEC_END:    state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Memory control for each state.
  always_comb begin
    mem_wr = '0;
    raddr  = cur;
    unique case (state)
      ST_INIT: begin
        mem_wr.we_left  = 1'b1;
        mem_wr.we_right = 1'b1;
        mem_wr.addr     = 8'd0;
        mem_wr.wdata    = LINK_NONE;
      end
      ST_WALK: begin
        raddr = link_sel.val;
        if ((bits_left == 5'd1) && (link_sel.kind != KIND_NODE)) begin
          mem_wr.we_left  = ~cur_dir;
          mem_wr.we_right = cur_dir;
          mem_wr.addr     = cur;
          mem_wr.wdata    = '{kind: KIND_LEAF, val: sym_reg};
        end
      end
      ST_ALLOC_CLR: begin
        mem_wr.we_left  = 1'b1;
        mem_wr.we_right = 1'b1;
        mem_wr.addr     = nodes_used[7:0];
        mem_wr.wdata    = LINK_NONE;
      end
      ST_ALLOC_LINK: begin
        mem_wr.we_left  = ~cur_dir;
        mem_wr.we_right = cur_dir;
        mem_wr.addr     = cur;
        mem_wr.wdata    = '{kind: KIND_NODE, val: nodes_used[7:0]};
      end
      ST_LEAF: begin
        mem_wr.we_left  = ~cur_dir;
        mem_wr.we_right = cur_dir;
        mem_wr.addr     = cur;
        mem_wr.wdata    = '{kind: KIND_LEAF, val: sym_reg};
      end
      ST_DEC_RD: raddr = current_node;
      ST_DEC:    raddr = dec_node_next;
      ST_IDLE, ST_NORM, ST_WALK_RD, ST_DEC_END: begin
        raddr = cur;
      end
      default: raddr = cur;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      nodes_used    <= 9'd1;
      current_node  <= 8'd0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= 1'b0;
      unique case (state)
        ST_ALLOC_LINK: nodes_used <= nodes_used + 9'd1;
        ST_DEC: begin
          current_node <= dec_node_next;
          if (link_sel.kind != KIND_NODE) begin
            pend_valid <= 1'b1;
            if (pend_valid) begin
              result_strobe <= 1'b1;
            end
          end
        end
        ST_DEC_END: begin
          pend_valid    <= 1'b0;
          result_strobe <= pend_valid;
        end
        default: begin
          nodes_used <= nodes_used;
        end
      endcase
    end
  end

  // Datapath registers: shift registers, counters and result payload.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          code_sr   <= code_word;
          bits_left <= 5'd31;
          sym_reg   <= symbol;
          cur       <= 8'd0;
          data_sr   <= data_byte;
          cnt       <= cnt_start;
        end
      end
      ST_NORM: begin
        code_sr <= {code_sr[30:0], 1'b0};
        if (!code_sr[31]) begin
          bits_left <= bits_left - 5'd1;
        end
      end
      ST_WALK: begin
        if (link_sel.kind == KIND_NODE) begin
          cur       <= link_sel.val;
          code_sr   <= {code_sr[30:0], 1'b0};
          bits_left <= bits_left - 5'd1;
        end
      end
      ST_ALLOC_LINK: begin
        cur       <= nodes_used[7:0];
        code_sr   <= {code_sr[30:0], 1'b0};
        bits_left <= bits_left - 5'd1;
      end
      ST_DEC: begin
        data_sr <= {data_sr[6:0], 1'b0};
        cnt     <= cnt - 4'd1;
        if (link_sel.kind != KIND_NODE) begin
          pend_bad       <= (link_sel.kind != KIND_LEAF);
          pend_symbol    <= (link_sel.kind == KIND_LEAF) ? link_sel.val : 8'd0;
          decoded_symbol <= pend_symbol;
          bad_code       <= pend_bad;
          last           <= 1'b0;
        end
      end
      ST_DEC_END: begin
        decoded_symbol <= pend_symbol;
        bad_code       <= pend_bad;
        last           <= 1'b1;
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  // A flagged bad code carries symbol zero.
  `HTD_ASSERT_NOW(a_bad_zero, clk, rst, result_strobe && bad_code, decoded_symbol == 8'd0, "bad code with nonzero symbol")
  // Each link step of an allocation takes exactly one fresh node.
  `HTD_ASSERT_NEXT(a_alloc_count, clk, rst, state == ST_ALLOC_LINK, nodes_used == $past(nodes_used) + 9'd1, "node count did not advance")
  // The table never gives out more nodes than it holds.
  `HTD_ASSERT_NOW(a_capacity, clk, rst, state == ST_ALLOC_CLR, nodes_used < 9'(NODE_CAPACITY), "node table overflow")
  // A pending result at the end of a byte leaves as the last one.
  `HTD_ASSERT_NEXT(a_last_flush, clk, rst, state == ST_DEC_END && pend_valid, result_strobe && last, "final result not flushed")
  // Results only come out of the decode walk.
  `HTD_ASSERT_NOW(a_strobe_src, clk, rst, result_strobe, $past(state) == ST_DEC || $past(state) == ST_DEC_END, "result outside decode")

endmodule

`default_nettype wire
